// File: sv/vlp_pkg.sv
package vlp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHAR  = 2'd1,
        ST_BAD_BASE  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LEAD   = 4'b0010,
        PH_BASE   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        BK_DEC = 2'd0,
        BK_BIN = 2'd1,
        BK_OCT = 2'd2,
        BK_HEX = 2'd3
    } base_t;

    localparam int unsigned DCOUNT_BITS = 8;
    localparam logic [DCOUNT_BITS-1:0] DCOUNT_MAX = {DCOUNT_BITS{1'b1}};

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

endpackage

// File: sv/verilog_literal_parser_top.sv
// Verilog number literal parser: one character word per cycle.
// The last character is captured in the input register, then the combinational parse step
// writes the result word into the result register.
// Throughput: one character per cycle; the input stalls only while a finished
// result is held by a stalled output and the next last character is waiting.
// Reset (rst_n, asynchronous, active low) clears the parser state and both valid flags.
module verilog_literal_parser_top #(
    parameter int VALUE_BITS  = 64,
    parameter int LENGTH_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              char_code,
    input  logic                    last_char,
    input  logic                    char_valid,
    output logic                    char_stall,
    output vlp_pkg::status_t        status,
    output logic [VALUE_BITS-1:0]   value_bits,
    output logic [LENGTH_BITS-1:0]  bit_length,
    output logic                    result_valid,
    input  logic                    result_stall
);
    import vlp_pkg::*;

    localparam int WIDE_BITS = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    logic [7:0]              s1_char_reg;
    logic                    s1_last_reg;
    logic                    s1_valid_reg;

    phase_t                  phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]  width_reg, width_next;
    logic                    wgiven_reg, wgiven_next;
    base_t                   base_reg, base_next;
    logic [DCOUNT_BITS-1:0]  dcount_reg, dcount_next;
    status_t                 err_reg, err_next;
    logic                    trail_reg, trail_next;

    status_t                 status_reg, status_next;
    logic [VALUE_BITS-1:0]   value_reg, value_next;
    logic [LENGTH_BITS-1:0]  length_reg, length_next;
    logic                    out_valid_reg;

    logic                    advance;
    logic                    fire;
    logic                    char_accept;
    logic                    load_result;

    logic [7:0]              ch;
    logic                    is_space;
    logic                    is_dec;
    logic                    is_hex_letter;
    logic [3:0]              dec_digit;
    logic [3:0]              shift_digit;
    logic [2:0]              shift_bits;
    logic                    digit_ok;
    logic [VALUE_BITS-1:0]   acc_x10;
    logic [VALUE_BITS-1:0]   acc_shifted;
    logic [WIDE_BITS-1:0]    width_wide;
    logic [WIDE_BITS-1:0]    width_x10;
    logic [DCOUNT_BITS:0]    dcount_sum;
    logic [DCOUNT_BITS-1:0]  dcount_sat;
    logic [LENGTH_BITS-1:0]  dec_length;
    logic [LENGTH_BITS-1:0]  base_length;
    status_t                 final_err;

    // A last character may only move on once the result register is free.
    assign advance     = !s1_last_reg || !out_valid_reg || !result_stall;
    assign char_stall  = s1_valid_reg && !advance;
    assign char_accept = char_valid && !char_stall;
    assign fire        = s1_valid_reg && advance;
    assign load_result = fire && s1_last_reg;

    // Decode of the current character, letters folded to lower case.
    always_comb
    begin
        ch = s1_char_reg;
        if (ch >= CH_UP_A && ch <= CH_UP_Z)
        begin
            ch = ch + CASE_DELTA;
        end
        is_space      = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        is_dec        = (ch >= CH_0) && (ch <= CH_9);
        is_hex_letter = (ch >= CH_A) && (ch <= CH_F);
        dec_digit     = 4'(ch - CH_0);
        acc_x10       = (acc_reg << 3) + (acc_reg << 1) + VALUE_BITS'(dec_digit);
        width_wide    = WIDE_BITS'(width_reg);
        width_x10     = (width_wide << 3) + (width_wide << 1) + WIDE_BITS'(dec_digit);
    end

    // Digit check for every base, and shift amount for the binary, octal and hex bases.
    always_comb
    begin
        shift_digit = dec_digit;
        shift_bits  = 3'd4;
        digit_ok    = is_dec;
        case (base_reg)
            BK_BIN:
            begin
                shift_bits = 3'd1;
                digit_ok   = (ch == CH_0) || (ch == CH_1);
            end
            BK_OCT:
            begin
                shift_bits = 3'd3;
                digit_ok   = (ch >= CH_0) && (ch <= CH_7);
            end
            BK_HEX:
            begin
                shift_bits = 3'd4;
                digit_ok   = is_dec || is_hex_letter;
                if (is_hex_letter)
                begin
                    shift_digit = 4'(ch - CH_A + HEX_LETTER_OFS);
                end
            end
            default:
            begin
                shift_bits = 3'd4;
                digit_ok   = is_dec;
            end
        endcase
        acc_shifted = (acc_reg << shift_bits) | VALUE_BITS'(shift_digit);
        dcount_sum  = (DCOUNT_BITS + 1)'(dcount_reg) + (DCOUNT_BITS + 1)'(shift_bits);
        dcount_sat  = dcount_sum[DCOUNT_BITS] ? DCOUNT_MAX : dcount_sum[DCOUNT_BITS-1:0];
    end

    // One parse step. Once an error is latched, characters are dropped.
    always_comb
    begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        wgiven_next = wgiven_reg;
        base_next   = base_reg;
        dcount_next = dcount_reg;
        err_next    = err_reg;
        trail_next  = trail_reg;
        if (err_reg == ST_OK)
        begin
            if (is_space)
            begin
                if (phase_reg == PH_BASE)
                begin
                    err_next = ST_BAD_BASE;
                end
                else if (phase_reg != PH_IDLE)
                begin
                    trail_next = 1'b1;
                end
            end
            else if (trail_reg)
            begin
                err_next = ST_BAD_CHAR;
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_IDLE, PH_LEAD:
                    begin
                        if (is_dec)
                        begin
                            acc_next = acc_x10;
                            if (width_x10 > WIDE_BITS'(LEN_MAX))
                            begin
                                width_next = LEN_MAX;
                            end
                            else
                            begin
                                width_next = width_x10[LENGTH_BITS-1:0];
                            end
                            phase_next = PH_LEAD;
                        end
                        else if (ch == CH_QUOTE)
                        begin
                            wgiven_next = (phase_reg == PH_LEAD);
                            if (phase_reg != PH_LEAD)
                            begin
                                width_next = '0;
                            end
                            acc_next   = '0;
                            phase_next = PH_BASE;
                        end
                        else
                        begin
                            err_next = ST_BAD_CHAR;
                        end
                    end
                    PH_BASE:
                    begin
                        if (ch == CH_B)
                        begin
                            base_next = BK_BIN;
                        end
                        else if (ch == CH_O)
                        begin
                            base_next = BK_OCT;
                        end
                        else if (ch == CH_D)
                        begin
                            base_next = BK_DEC;
                        end
                        else if (ch == CH_H)
                        begin
                            base_next = BK_HEX;
                        end
                        else
                        begin
                            err_next = ST_BAD_BASE;
                        end
                        phase_next = PH_DIGITS;
                    end
                    PH_DIGITS:
                    begin
                        if (!digit_ok)
                        begin
                            err_next = ST_BAD_CHAR;
                        end
                        else if (base_reg == BK_DEC)
                        begin
                            acc_next = acc_x10;
                        end
                        else
                        begin
                            acc_next    = acc_shifted;
                            dcount_next = dcount_sat;
                        end
                    end
                    default:
                    begin
                        err_next = err_reg;
                    end
                endcase
            end
        end
    end

    // Minimal binary length of the decimal value, at least one.
    always_comb
    begin
        dec_length = LENGTH_BITS'(1);
        for (int i = 1; i < VALUE_BITS; i++)
        begin
            if (acc_next[i])
            begin
                dec_length = LENGTH_BITS'(i + 1);
            end
        end
    end

    // Result word, formed from the state after the last character.
    always_comb
    begin
        final_err = err_next;
        if (err_next == ST_OK && phase_next == PH_BASE)
        begin
            final_err = ST_BAD_BASE;
        end
        else if (err_next == ST_OK && base_next != BK_DEC
                 && dcount_next > DCOUNT_BITS'(VALUE_BITS))
        begin
            final_err = ST_OVERFLOW;
        end
        base_length = (base_next == BK_DEC) ? dec_length : LENGTH_BITS'(dcount_next);
        if (wgiven_next && width_next > base_length)
        begin
            base_length = width_next;
        end
        status_next = final_err;
        if (final_err == ST_OK)
        begin
            value_next  = acc_next;
            length_next = base_length;
        end
        else
        begin
            value_next  = '0;
            length_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (char_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            acc_reg    <= '0;
            width_reg  <= '0;
            wgiven_reg <= 1'b0;
            base_reg   <= BK_DEC;
            dcount_reg <= '0;
            err_reg    <= ST_OK;
            trail_reg  <= 1'b0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                phase_reg  <= PH_IDLE;
                acc_reg    <= '0;
                width_reg  <= '0;
                wgiven_reg <= 1'b0;
                base_reg   <= BK_DEC;
                dcount_reg <= '0;
                err_reg    <= ST_OK;
                trail_reg  <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                width_reg  <= width_next;
                wgiven_reg <= wgiven_next;
                base_reg   <= base_next;
                dcount_reg <= dcount_next;
                err_reg    <= err_next;
                trail_reg  <= trail_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            length_reg <= length_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign value_bits   = value_reg;
    assign bit_length   = length_reg;

endmodule
